@@ rtl/sha_pkg.sv @@
// shared types, constants and the rotate function for the sha-256 hasher
package sha_pkg;

    localparam int unsigned QueueDepth = 4;
    localparam logic [7:0] PadByte = 8'h80;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last_item;
    } t_item;

    typedef logic [31:0] t_word;

    localparam t_word InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word ror(input t_word v, input int unsigned n);
        ror = (v >> n) | (v << (32 - n));
    endfunction

endpackage

@@ rtl/sha_queue.sv @@
// small request queue between the input front and the hash engine
module sha_queue #(
    parameter int unsigned DEPTH = sha_pkg::QueueDepth
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sha_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output sha_pkg::t_item o_item
);
    import sha_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_item            r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push && !o_full) - (AW+1)'(i_pop && !o_empty);
        end
    end
endmodule

@@ rtl/sha_engine.sv @@
// block assembly, padding, 64-round compression and digest output
module sha_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  sha_pkg::t_item i_item,
    output logic           o_pop,
    output logic [31:0]    o_word,
    output logic [2:0]     o_index,
    output logic           o_last,
    output logic           o_valid,
    input  logic           i_ready
);
    import sha_pkg::*;

    typedef enum logic [4:0] {
        S_TAKE  = 5'b00001,
        S_ROUND = 5'b00010,
        S_ADD   = 5'b00100,
        S_PAD   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state      r_state;
    t_word       r_blk [16];
    t_word       r_h [8];
    t_word       r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h7;
    logic [5:0]  r_fill;
    logic [60:0] r_len;
    logic [5:0]  r_rnd;
    logic [2:0]  r_oi;
    // final: this compression ends the message; second: length block still due
    logic        r_final, r_second;

    t_word w_cur, w_new, t1, t2, s0, s1;
    logic [63:0] bits;

    assign w_cur = r_blk[0];
    assign s0 = ror(r_blk[1], 7) ^ ror(r_blk[1], 18) ^ (r_blk[1] >> 3);
    assign s1 = ror(r_blk[14], 17) ^ ror(r_blk[14], 19) ^ (r_blk[14] >> 10);
    assign w_new = r_blk[0] + s0 + r_blk[9] + s1;
    assign t1 = r_h7 + (ror(r_e, 6) ^ ror(r_e, 11) ^ ror(r_e, 25))
              + ((r_e & r_f) ^ (~r_e & r_g)) + RoundK[r_rnd] + w_cur;
    assign t2 = (ror(r_a, 2) ^ ror(r_a, 13) ^ ror(r_a, 22))
              + ((r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c));
    assign bits = {r_len, 3'b000};

    assign o_pop   = (r_state == S_TAKE) && !i_empty;
    assign o_valid = (r_state == S_OUT);
    assign o_word  = r_h[r_oi];
    assign o_index = r_oi;
    assign o_last  = (r_oi == 3'd7);

    function automatic t_word put(input t_word w, input logic [1:0] p, input logic [7:0] v);
        t_word m;
        m = w;
        m[(3 - p) * 8 +: 8] = v;
        put = m;
    endfunction

    // pad from fill point: pad byte, zeros, then length if it fits
    task automatic pad_block(input logic [5:0] pos, input logic wlen);
        for (int i = 0; i < 16; i++) begin
            t_word w;
            w = r_blk[i];
            for (int j = 0; j < 4; j++) begin
                if (6'(i * 4 + j) == pos) w[(3 - j) * 8 +: 8] = PadByte;
                else if (6'(i * 4 + j) > pos) w[(3 - j) * 8 +: 8] = 8'h00;
            end
            if (wlen && i == 14) w = bits[63:32];
            if (wlen && i == 15) w = bits[31:0];
            r_blk[i] <= w;
        end
    endtask

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_TAKE;
            r_fill <= '0;
            r_len <= '0;
            r_rnd <= '0;
            r_oi <= '0;
            r_final <= 1'b0;
            r_second <= 1'b0;
            for (int i = 0; i < 8; i++) r_h[i] <= InitHash[i];
        end else begin
            case (r_state)
                S_TAKE: begin
                    if (!i_empty) begin
                        if (i_item.byte_present) begin
                            r_blk[r_fill[5:2]] <= put(r_blk[r_fill[5:2]], r_fill[1:0],
                                                      i_item.data_byte);
                            r_fill <= r_fill + 1'b1;
                            r_len <= r_len + 1'b1;
                        end
                        r_final <= i_item.last_item;
                        if (i_item.byte_present && r_fill == 6'd63) begin
                            r_second <= i_item.last_item;
                            r_state <= S_ROUND;
                        end else if (i_item.last_item) begin
                            r_state <= S_PAD;
                        end
                        r_rnd <= '0;
                        {r_a, r_b, r_c, r_d} <= {r_h[0], r_h[1], r_h[2], r_h[3]};
                        {r_e, r_f, r_g, r_h7} <= {r_h[4], r_h[5], r_h[6], r_h[7]};
                    end
                end
                S_PAD: begin
                    // length fits only when fill is 55 or less
                    pad_block(r_fill, r_fill <= 6'd55);
                    r_second <= (r_fill > 6'd55);
                    r_rnd <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_h7 <= r_g; r_g <= r_f; r_f <= r_e; r_e <= r_d + t1;
                    r_d <= r_c; r_c <= r_b; r_b <= r_a; r_a <= t1 + t2;
                    for (int i = 0; i < 15; i++) r_blk[i] <= r_blk[i + 1];
                    r_blk[15] <= w_new;
                    r_rnd <= r_rnd + 1'b1;
                    if (r_rnd == 6'd63) r_state <= S_ADD;
                end
                S_ADD: begin
                    r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c; r_h[3] <= r_h[3] + r_d;
                    r_h[4] <= r_h[4] + r_e; r_h[5] <= r_h[5] + r_f;
                    r_h[6] <= r_h[6] + r_g; r_h[7] <= r_h[7] + r_h7;
                    r_oi <= '0;
                    if (r_second) begin
                        // length-only block, led by the pad byte when the data filled a block
                        for (int i = 1; i < 14; i++) r_blk[i] <= '0;
                        r_blk[0] <= (r_fill == 6'd0) ? {PadByte, 24'h0} : '0;
                        r_blk[14] <= bits[63:32];
                        r_blk[15] <= bits[31:0];
                        r_fill <= '0;
                        r_second <= 1'b0;
                        r_state <= S_ROUND;
                        r_rnd <= '0;
                    end else if (r_final) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_TAKE;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_oi <= r_oi + 1'b1;
                        if (r_oi == 3'd7) begin
                            for (int i = 0; i < 8; i++) r_h[i] <= InitHash[i];
                            r_fill <= '0;
                            r_len <= '0;
                            r_final <= 1'b0;
                            r_state <= S_TAKE;
                        end
                    end
                end
                default: r_state <= S_TAKE;
            endcase
            if (r_state == S_ADD && r_second) begin
                r_a <= r_h[0] + r_a; r_b <= r_h[1] + r_b;
                r_c <= r_h[2] + r_c; r_d <= r_h[3] + r_d;
                r_e <= r_h[4] + r_e; r_f <= r_h[5] + r_f;
                r_g <= r_h[6] + r_g; r_h7 <= r_h[7] + r_h7;
            end
        end
    end
endmodule

@@ rtl/sha256_message_hasher.sv @@
// top level of the sha-256 message hasher
// channel  dir  handshake            payload
// s_axis   in   tvalid/tready        tdata = data_byte, tuser = byte_present, tlast = last_item
// m_axis   out  tvalid/tready        tdata = digest_word, tuser = word_index, tlast = last_word
// a full block runs through the single round unit and then an add step; padding takes
// a step of its own, plus a second block when the length does not fit; the digest
// leaves at one word a cycle while the receiver is ready.
// reset is synchronous, active low, and restores the initial hash values.
// input stalls only when the queue is full; output stalls hold the current word.
module sha256_message_hasher #(
    parameter int unsigned QUEUE_DEPTH = sha_pkg::QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // byte_present
    input  logic        s_axis_tlast,   // last_item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic [2:0]  m_axis_tuser,   // word_index
    output logic        m_axis_tlast    // last_word
);
    import sha_pkg::*;

    t_item in_item, q_item;
    logic  q_full, q_empty, q_pop;

    assign in_item = '{data_byte: s_axis_tdata, byte_present: s_axis_tuser,
                       last_item: s_axis_tlast};
    assign s_axis_tready = !q_full;

    sha_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(s_axis_tvalid), .i_item(in_item), .o_full(q_full),
        .i_pop(q_pop), .o_empty(q_empty), .o_item(q_item)
    );

    sha_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_empty(q_empty), .i_item(q_item), .o_pop(q_pop),
        .o_word(m_axis_tdata), .o_index(m_axis_tuser), .o_last(m_axis_tlast),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready)
    );
endmodule

@@ sim/tb.sv @@
// testbench for the sha-256 message hasher: byte streams checked against a built-in digest model
`timescale 1ns / 1ps

import sha_pkg::*;

typedef struct {
    t_word    word;
    bit [2:0] index;
    bit       last;
} t_digest_word;

class digest_board;
    t_word        hash [8];
    bit [7:0]     msg [$];
    bit [60:0]    msg_len;
    t_digest_word pending [$];
    int           errors;

    task report_error(string msg_txt);
        $display("tb: mismatch: %s", msg_txt);
        errors++;
    endtask

    function void init_state();
        for (int i = 0; i < 8; i++) hash[i] = InitHash[i];
        msg.delete();
        msg_len = '0;
    endfunction

    function t_word rot(t_word v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function void compress(bit [7:0] blk [64]);
        t_word w [64];
        t_word a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + (rot(w[i-15], 7) ^ rot(w[i-15], 18) ^ (w[i-15] >> 3))
                 + w[i-7] + (rot(w[i-2], 17) ^ rot(w[i-2], 19) ^ (w[i-2] >> 10));
        a = hash[0]; b = hash[1]; c = hash[2]; d = hash[3];
        e = hash[4]; f = hash[5]; g = hash[6]; h = hash[7];
        for (int i = 0; i < 64; i++) begin
            t1 = h + (rot(e, 6) ^ rot(e, 11) ^ rot(e, 25)) + ((e & f) ^ (~e & g))
               + RoundK[i] + w[i];
            t2 = (rot(a, 2) ^ rot(a, 13) ^ rot(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash[0] += a; hash[1] += b; hash[2] += c; hash[3] += d;
        hash[4] += e; hash[5] += f; hash[6] += g; hash[7] += h;
    endfunction

    function void note_request(bit [7:0] data, bit present, bit last);
        bit [7:0]  blk [64];
        bit [63:0] bits;
        int        n;
        if (present) begin
            msg.push_back(data);
            msg_len++;
            if (msg.size() == 64) begin
                foreach (blk[i]) blk[i] = msg[i];
                compress(blk);
                msg.delete();
            end
        end
        if (!last) return;
        n = msg.size();
        foreach (blk[i]) blk[i] = (i < n) ? msg[i] : 8'h00;
        blk[n] = PadByte;
        if (n > 55) begin
            compress(blk);
            foreach (blk[i]) blk[i] = 8'h00;
        end
        bits = {msg_len, 3'b000};
        for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
        compress(blk);
        for (int i = 0; i < 8; i++)
            pending.push_back('{hash[i], 3'(i), i == 7});
        init_state();
    endfunction

    task check_word(t_word word, bit [2:0] index, bit last);
        t_digest_word exp_w;
        if (pending.size() == 0) begin
            report_error($sformatf("unexpected digest word %h", word));
            return;
        end
        exp_w = pending.pop_front();
        if (word !== exp_w.word || index !== exp_w.index || last !== exp_w.last)
            report_error($sformatf("got %h/%0d/%0d want %h/%0d/%0d",
                word, index, last, exp_w.word, exp_w.index, exp_w.last));
    endtask
endclass

module tb;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 0;   // data_byte
    logic        s_axis_tuser = 0;   // byte_present
    logic        s_axis_tlast = 0;   // last_item
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [31:0] m_axis_tdata;       // digest_word
    logic [2:0]  m_axis_tuser;       // word_index
    logic        m_axis_tlast;       // last_word

    digest_board board = new();
    int          burst_left = 0;
    bit          hold_off = 0;

    sha256_message_hasher dut (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    // sampling at the edge sees pre-update values, so order within the step does not matter
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    // receiver stall pattern: mostly ready, some stretches of random stalls
    always @(posedge i_clk) begin
        int phase;
        phase = int'($urandom_range(0, 99));
        if (hold_off) m_axis_tready <= 0;
        else if (phase < 30 && $urandom_range(0, 3) != 0)
            m_axis_tready <= 1'($urandom_range(0, 1));
        else m_axis_tready <= 1;
    end

    // the sender always waits on the clock before a new burst, so valid never drops and rises in one step
    task automatic send_request(bit [7:0] data, bit present, bit last);
        while (burst_left == 0) begin
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 80))
                                                     : int'($urandom_range(1, 20));
        end
        burst_left--;
        s_axis_tvalid <= 1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= present;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_request(data, present, last);
        if (burst_left == 0) s_axis_tvalid <= 0;
    endtask

    task automatic end_burst();
        if (burst_left != 0) begin
            burst_left = 0;
            s_axis_tvalid <= 0;
        end
    endtask

    task automatic send_message(int len, bit end_with_byte);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0) send_request(8'($urandom), 0, 0);
            send_request(8'($urandom), 1, end_with_byte && i == len - 1);
        end
        if (!end_with_byte || len == 0) send_request(8'($urandom), 0, 1);
    endtask

    task automatic drain();
        end_burst();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    initial begin
        board.init_state();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: empty message, single bytes at extremes, empty items, pad edges
        send_request(8'h00, 0, 1);
        send_request(8'hff, 1, 1);
        send_request(8'h00, 0, 0);
        send_request(8'h00, 1, 0);
        send_request(8'h5a, 0, 0);
        send_request(8'ha5, 1, 1);
        send_message(55, 1);
        send_message(56, 0);
        send_message(64, 1);
        drain();
        // long receiver stall while the sender keeps offering
        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge i_clk);
                hold_off = 0;
            end
            begin
                send_message(3, 1);
                send_message(0, 0);
                send_message(2, 0);
                send_message(1, 1);
                end_burst();
            end
        join
        drain();
        // a few short random messages
        repeat (3) begin
            int len;
            len = int'($urandom_range(0, 10));
            send_message(len, 1'($urandom_range(0, 1)));
        end
        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial begin
        #400us;
        $display("tb: done, errors");
        $finish;
    end
endmodule
